>>> hw/rtl/let_pkg.sv
// Shared constants, codes and control structs for the label equivalence table.
// Used by let_ctrl, let_dpath and label_equivalence_table_top.
package let_pkg;

   // Table size and derived widths.
   localparam int LABELS    = 4096;
   localparam int LABEL_W   = 12;
   localparam int MEM_DEPTH = (LABELS < 4096) ? LABELS : 4096;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(LABELS + 1);
   localparam logic [LABEL_W-1:0] TOP_ID = LABEL_W'(MEM_DEPTH - 1);

   // Stream layout.
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_REMAP    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESOLVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ALLOCATE = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic issue_read;
      logic advance;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_resolve;
      logic cur_identity;
      logic count_full;
      logic link_self;
   } ctrl_sts_type;

endpackage

>>> hw/rtl/label_equivalence_table_top.sv
// Flow: a request is captured in the idle state, then passes the work state and the finish
// state; finish waits until the output register is free and then loads it. Resolve reads the
// table once per step (work issues a registered memory read, read checks it) and ends on a
// self-pointing entry, on a label above the highest id, or on a flagged chain loop.
// One request is in work at a time; the next is taken the cycle after a result
// is produced. Reset is synchronous: highest id goes to zero.
module label_equivalence_table_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [let_pkg::REQ_DATA_W-1:0]   req_tdata,  // label [11:0], target_label [23:12]
   input  logic [let_pkg::KIND_W-1:0]       req_tuser,  // kind [1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [let_pkg::RSP_DATA_W-1:0]   rsp_tdata   // result_label [11:0], status [13:12]
);

   let_pkg::ctrl_cmd_type cmd;
   let_pkg::ctrl_sts_type sts;

   // Controller.
   let_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   let_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> hw/rtl/let_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module let_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/let_ctrl.sv
// Controller state machine for the label equivalence table.
// Depends on let_pkg; drives let_dpath through command and status structs.
module let_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  let_pkg::ctrl_sts_type sts,
   output let_pkg::ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WORK   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   // The output register can take a result when empty or being drained.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_WORK;
            end
         end
         ST_WORK: begin
            // A request that is not a resolve, or a chase that has ended, finishes.
            if (!sts.is_resolve || sts.count_full || sts.cur_identity) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue_read = 1'b1;
               state_in       = ST_READ;
            end
         end
         ST_READ: begin
            if (sts.link_self) begin
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in    = ST_WORK;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output valid flag.
   always_comb begin
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A memory read is only ever issued from the work state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> ($past(state_ff) == ST_WORK))
      else $error("read state entered without a read being issued");

   // A read is never issued once the step limit has been reached.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> !sts.count_full)
      else $error("table read issued past the step limit");

   // A new result appears only after the finish state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result presented without finishing a request");
`endif

endmodule

>>> hw/rtl/let_dpath.sv
// Datapath for the label equivalence table: table memory, highest id, chase
// registers and output register. Depends on let_pkg and let_ram.
module let_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [let_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic [let_pkg::KIND_W-1:0]           req_tuser,
   input  let_pkg::ctrl_cmd_type                cmd,
   output let_pkg::ctrl_sts_type                sts,
   output logic [let_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic [let_pkg::KIND_W-1:0]     kind_ff;
   logic [let_pkg::LABEL_W-1:0]    label_ff;
   logic [let_pkg::LABEL_W-1:0]    target_ff;
   logic [let_pkg::LABEL_W-1:0]    cur_ff;
   logic [let_pkg::CNT_W-1:0]      count_ff;
   logic [let_pkg::LABEL_W-1:0]    highest_ff;
   logic [let_pkg::LABEL_W-1:0]    highest_in;
   logic [let_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [let_pkg::LABEL_W-1:0]    rd_data;
   logic                           wr_en;
   logic [let_pkg::ADDR_W-1:0]     wr_addr;
   logic [let_pkg::LABEL_W-1:0]    wr_data;
   logic [let_pkg::LABEL_W-1:0]    next_id;
   logic                           remap_ok;
   logic                           alloc_ok;
   logic [let_pkg::LABEL_W-1:0]    res_label;
   logic [let_pkg::STATUS_W-1:0]   res_status;

   // Entries above the highest id always hold themselves, so only allocated
   // entries live in memory. Entry zero is written during reset and every
   // other entry when its id is allocated, so no clearing pass is needed.
   let_ram #(
      .WIDTH (let_pkg::LABEL_W),
      .DEPTH (let_pkg::MEM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.issue_read),
      .rd_addr (cur_ff[let_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Status toward the controller.
   assign sts.is_resolve   = (kind_ff == let_pkg::KIND_RESOLVE);
   assign sts.cur_identity = (cur_ff > highest_ff);
   assign sts.count_full   = (count_ff == let_pkg::CNT_W'(let_pkg::LABELS));
   assign sts.link_self    = (rd_data == cur_ff);

   assign next_id  = highest_ff + let_pkg::LABEL_W'(1);
   assign remap_ok = (label_ff <= highest_ff) && (target_ff <= highest_ff);
   assign alloc_ok = (highest_ff < let_pkg::TOP_ID);

   // Result and table update for the finishing request.
   always_comb begin
      res_label  = '0;
      res_status = let_pkg::STATUS_OK;
      wr_en      = 1'b0;
      wr_addr    = label_ff[let_pkg::ADDR_W-1:0];
      wr_data    = target_ff;
      highest_in = highest_ff;
      unique case (kind_ff)
         let_pkg::KIND_REMAP: begin
            res_status = remap_ok ? let_pkg::STATUS_OK : let_pkg::STATUS_IGNORED;
            wr_en      = cmd.finish && remap_ok;
         end
         let_pkg::KIND_RESOLVE: begin
            if (sts.count_full) begin
               res_status = let_pkg::STATUS_CYCLE;
            end else begin
               res_label = cur_ff;
            end
         end
         let_pkg::KIND_ALLOCATE: begin
            if (alloc_ok) begin
               // A new entry starts out pointing to itself.
               res_label = next_id;
               wr_en     = cmd.finish;
               wr_addr   = next_id[let_pkg::ADDR_W-1:0];
               wr_data   = next_id;
               if (cmd.finish) begin
                  highest_in = next_id;
               end
            end else begin
               res_status = let_pkg::STATUS_FULL;
            end
         end
         default: begin
            res_status = let_pkg::STATUS_OK;
         end
      endcase
      // During reset entry zero is written to point at itself.
      if (reset) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = '0;
      end
   end

   // Request capture, chase registers and output register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         label_ff  <= req_tdata[11:0];
         target_ff <= req_tdata[23:12];
         cur_ff    <= req_tdata[11:0];
         count_ff  <= '0;
      end else if (cmd.advance) begin
         cur_ff   <= rd_data;
         count_ff <= count_ff + let_pkg::CNT_W'(1);
      end
      if (cmd.finish) begin
         rsp_data_ff <= {{(let_pkg::RSP_DATA_W - let_pkg::LABEL_W - let_pkg::STATUS_W){1'b0}},
                         res_status, res_label};
      end
   end

   // Highest allocated id.
   always_ff @(posedge clock) begin
      if (reset) begin
         highest_ff <= '0;
      end else begin
         highest_ff <= highest_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
